>>> rtl/maft_pkg.sv
// Shared constants, codes and types of the masked address filter table.
package maft_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   // request function codes
   localparam logic [2:0] FN_LOOKUP = 3'd0;
   localparam logic [2:0] FN_APPEND = 3'd1;
   localparam logic [2:0] FN_BAN    = 3'd2;
   localparam logic [2:0] FN_REMOVE = 3'd3;
   localparam logic [2:0] FN_READ   = 3'd4;
   localparam logic [2:0] FN_CLEAR  = 3'd5;

   // response status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_REPLACED  = 3'd1;
   localparam logic [2:0] ST_REMOVED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam logic [3:0] FLAG_BANNED = 4'b0001;

   typedef struct packed {
      logic [31:0] host;
      logic [31:0] mask;
      logic [3:0]  flags;
      logic        temporary;
   } entry_type;

   typedef struct packed {
      logic masked_hit;
      logic exact_hit;
   } match_type;

endpackage

>>> rtl/maft_match.sv
// Shared compare unit: masked and exact host match of one table entry.
module maft_match (
   input  maft_pkg::entry_type entry,
   input  logic [31:0]         key,
   output maft_pkg::match_type res
);
   import maft_pkg::*;

   assign res.masked_hit = ((key & entry.mask) == entry.host);
   assign res.exact_hit  = (entry.host == key);

endmodule

>>> rtl/masked_address_filter_table.sv
// Top level of the masked address filter table: sequencer, entry memory and result register.
// Ordered first-match IPv4 filter table with up to TABLE_ENTRIES host/mask entries.
// Request channel (req_valid/req_ready): one request carries req_func and its operands.
// The block takes one request at a time; req_ready is high only while the sequencer
// is idle. Response channel (rsp_valid/rsp_ready): one response per request, held in
// an output register, so a new request is taken while the previous response waits.
// Append, clear and an unknown function finish without a scan; a read of a held
// position fetches that entry; lookup scans until the first hit; remove and ban scan
// every entry, and a ban that inserts at the front then moves every entry back by one.
// The time a request takes is set by the scan of the entry memory: one read and one
// write per cycle, with the read data registered, and one shared compare unit.
// Reset clears the sequencer, the entry count and the response register; the entry
// memory keeps its contents and needs no clearing, since only positions below the
// entry count are ever read.
// A stalled receiver holds the response register; a finished request then waits in
// its last state until the register is free.
module masked_address_filter_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_host_addr,
   input  logic [31:0] req_net_mask,
   input  logic [3:0]  req_policy_flags,
   input  logic [5:0]  req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_hit,
   output logic [3:0]  rsp_result_flags,
   output logic [31:0] rsp_entry_host,
   output logic [31:0] rsp_entry_mask,
   output logic        rsp_entry_temporary,
   output logic [6:0]  rsp_entry_count
);
   import maft_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      SHIFT,
      FETCH,
      FINISH
   } state_type;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   // sequencer state
   state_type        state_ff, state_in;
   logic [2:0]       func_ff, func_in;
   logic [31:0]      addr_ff, addr_in;
   logic [31:0]      mask_ff, mask_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] dp_ff, dp_in;
   logic             dv_ff, dv_in;
   logic [CNT_W-1:0] w_ff, w_in;
   logic             found_ff, found_in;

   // staged result
   logic [2:0]  stg_status_ff, stg_status_in;
   logic        stg_hit_ff, stg_hit_in;
   logic [3:0]  stg_flags_ff, stg_flags_in;
   logic [31:0] stg_host_ff, stg_host_in;
   logic [31:0] stg_mask_ff, stg_mask_in;
   logic        stg_temp_ff, stg_temp_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic [3:0]  rsp_flags_ff, rsp_flags_in;
   logic [31:0] rsp_host_ff, rsp_host_in;
   logic [31:0] rsp_mask_ff, rsp_mask_in;
   logic        rsp_temp_ff, rsp_temp_in;
   logic [6:0]  rsp_count_ff, rsp_count_in;

   // entry memory
   entry_type        mem [TABLE_ENTRIES];
   entry_type        rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   match_type        match;
   entry_type        ban_entry;
   logic [CNT_W-1:0] rd_prev;
   logic [CNT_W-1:0] dp_next;
   logic             table_full;
   logic             index_ok;

   maft_match u_match (
      .entry (rd_data_ff),
      .key   (addr_ff),
      .res   (match)
   );

   assign req_ready = (state_ff == IDLE);

   assign ban_entry  = '{host: addr_ff, mask: mask_ff, flags: FLAG_BANNED, temporary: 1'b1};
   assign rd_prev    = rd_ptr_ff - 1'b1;
   assign dp_next    = dp_ff + 1'b1;
   assign table_full = (count_ff == FULL_COUNT);
   assign index_ok   = (CMP_W'(req_entry_index) < CMP_W'(count_ff));

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      addr_in       = addr_ff;
      mask_in       = mask_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      dp_in         = dp_ff;
      dv_in         = 1'b0;
      w_in          = w_ff;
      found_in      = found_ff;
      stg_status_in = stg_status_ff;
      stg_hit_in    = stg_hit_ff;
      stg_flags_in  = stg_flags_ff;
      stg_host_in   = stg_host_ff;
      stg_mask_in   = stg_mask_ff;
      stg_temp_in   = stg_temp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_flags_in  = rsp_flags_ff;
      rsp_host_in   = rsp_host_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = rd_ptr_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = dp_ff[IDX_W-1:0];
      wr_data       = rd_data_ff;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               // latch the request and start from a miss
               func_in       = req_func;
               addr_in       = req_host_addr;
               mask_in       = req_net_mask;
               rd_ptr_in     = '0;
               w_in          = '0;
               found_in      = 1'b0;
               stg_status_in = ST_NOT_FOUND;
               stg_hit_in    = 1'b0;
               stg_flags_in  = '0;
               stg_host_in   = '0;
               stg_mask_in   = '0;
               stg_temp_in   = 1'b0;
               state_in      = FINISH;
               unique case (req_func)
                  FN_LOOKUP, FN_BAN, FN_REMOVE: begin
                     state_in = SCAN;
                  end
                  FN_APPEND: begin
                     if (table_full) begin
                        stg_status_in = ST_FULL;
                     end else begin
                        // append at the tail, host stored already masked
                        wr_en         = 1'b1;
                        wr_addr       = count_ff[IDX_W-1:0];
                        wr_data       = '{host: req_host_addr & req_net_mask,
                                          mask: req_net_mask,
                                          flags: req_policy_flags,
                                          temporary: 1'b0};
                        count_in      = count_ff + 1'b1;
                        stg_status_in = ST_OK;
                     end
                  end
                  FN_READ: begin
                     if (index_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(req_entry_index);
                        state_in = FETCH;
                     end
                  end
                  FN_CLEAR: begin
                     count_in      = '0;
                     stg_status_in = ST_OK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         SCAN: begin
            // issue the next read while checking the previous entry
            if (rd_ptr_ff != count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in = rd_ptr_ff + 1'b1;
               dp_in     = rd_ptr_ff;
               dv_in     = 1'b1;
            end
            if (dv_ff) begin
               unique case (func_ff)
                  FN_LOOKUP: begin
                     if (match.masked_hit) begin
                        stg_status_in = ST_OK;
                        stg_hit_in    = 1'b1;
                        stg_flags_in  = rd_data_ff.flags;
                        state_in      = FINISH;
                     end
                  end
                  FN_BAN: begin
                     if (match.exact_hit) begin
                        wr_en    = 1'b1;
                        wr_addr  = dp_ff[IDX_W-1:0];
                        wr_data  = ban_entry;
                        found_in = 1'b1;
                     end
                  end
                  FN_REMOVE: begin
                     // keep entries that differ, packed towards the front
                     if (!match.exact_hit) begin
                        wr_en   = 1'b1;
                        wr_addr = w_ff[IDX_W-1:0];
                        wr_data = rd_data_ff;
                        w_in    = w_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (rd_ptr_ff == count_ff) begin
               // every entry checked
               state_in = FINISH;
               unique case (func_ff)
                  FN_BAN: begin
                     if (found_ff) begin
                        stg_status_in = ST_REPLACED;
                     end else if (table_full) begin
                        stg_status_in = ST_FULL;
                     end else begin
                        rd_ptr_in = count_ff;
                        state_in  = SHIFT;
                     end
                  end
                  FN_REMOVE: begin
                     stg_status_in = (w_ff != count_ff) ? ST_REMOVED : ST_NOT_FOUND;
                     count_in      = w_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end

         SHIFT: begin
            // move entries back by one, from the tail down
            if (rd_ptr_ff != '0) begin
               rd_en     = 1'b1;
               rd_addr   = rd_prev[IDX_W-1:0];
               rd_ptr_in = rd_prev;
               dp_in     = rd_prev;
               dv_in     = 1'b1;
            end
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = dp_next[IDX_W-1:0];
               wr_data = rd_data_ff;
            end else if (rd_ptr_ff == '0) begin
               // front slot free: insert the ban
               wr_en         = 1'b1;
               wr_addr       = '0;
               wr_data       = ban_entry;
               count_in      = count_ff + 1'b1;
               stg_status_in = ST_OK;
               state_in      = FINISH;
            end
         end

         FETCH: begin
            stg_status_in = ST_OK;
            stg_flags_in  = rd_data_ff.flags;
            stg_host_in   = rd_data_ff.host;
            stg_mask_in   = rd_data_ff.mask;
            stg_temp_in   = rd_data_ff.temporary;
            state_in      = FINISH;
         end

         FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stg_status_ff;
               rsp_hit_in    = stg_hit_ff;
               rsp_flags_in  = stg_flags_ff;
               rsp_host_in   = stg_host_ff;
               rsp_mask_in   = stg_mask_ff;
               rsp_temp_in   = stg_temp_ff;
               rsp_count_in  = 7'(count_ff);
               state_in      = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      addr_ff       <= addr_in;
      mask_ff       <= mask_in;
      rd_ptr_ff     <= rd_ptr_in;
      dp_ff         <= dp_in;
      w_ff          <= w_in;
      found_ff      <= found_in;
      stg_status_ff <= stg_status_in;
      stg_hit_ff    <= stg_hit_in;
      stg_flags_ff  <= stg_flags_in;
      stg_host_ff   <= stg_host_in;
      stg_mask_ff   <= stg_mask_in;
      stg_temp_ff   <= stg_temp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_flags_ff  <= rsp_flags_in;
      rsp_host_ff   <= rsp_host_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_result_flags    = rsp_flags_ff;
   assign rsp_entry_host      = rsp_host_ff;
   assign rsp_entry_mask      = rsp_mask_ff;
   assign rsp_entry_temporary = rsp_temp_ff;
   assign rsp_entry_count     = rsp_count_ff;

endmodule

>>> dv/masked_address_filter_table_test.sv
// Self-checking testbench of the masked address filter table.
`timescale 1ns / 1ps

module masked_address_filter_table_test;
   import maft_pkg::*;

   // function codes the block does not decode; they must leave the table alone
   localparam logic [2:0] FN_SPARE6 = 3'd6;
   localparam logic [2:0] FN_SPARE7 = 3'd7;

   localparam int POOL_SIZE      = 8;
   localparam int MAX_GAP        = 13;
   localparam int HOLD_OFF_LEN   = 400;
   localparam int SETTLE_CYCLES  = 2 * TABLE_ENTRIES + 20;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic [3:0]  flags;
      logic [31:0] host;
      logic [31:0] mask;
      logic        temporary;
      logic [6:0]  count;
   } filter_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = FN_LOOKUP;
   logic [31:0] req_host_addr = '0;
   logic [31:0] req_net_mask = '0;
   logic [3:0]  req_policy_flags = '0;
   logic [5:0]  req_entry_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_hit;
   logic [3:0]  rsp_result_flags;
   logic [31:0] rsp_entry_host;
   logic [31:0] rsp_entry_mask;
   logic        rsp_entry_temporary;
   logic [6:0]  rsp_entry_count;

   // shadow copy of the filter table, advanced on every accepted request
   logic [31:0] acl_host [TABLE_ENTRIES];
   logic [31:0] acl_mask [TABLE_ENTRIES];
   logic [3:0]  acl_flags [TABLE_ENTRIES];
   logic        acl_temp [TABLE_ENTRIES];
   int          acl_count = 0;

   filter_response_type awaited_responses[$];
   logic [31:0]         host_pool [POOL_SIZE];

   int unsigned req_taken = 0;
   int unsigned rsp_taken = 0;
   int unsigned idle_cycles = 0;
   int          error_count = 0;
   bit          source_quiet = 1'b0;
   bit          sink_quiet = 1'b0;
   int unsigned hold_off_cycles = 0;

   always #1 clock = ~clock;

   masked_address_filter_table dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_host_addr       (req_host_addr),
      .req_net_mask        (req_net_mask),
      .req_policy_flags    (req_policy_flags),
      .req_entry_index     (req_entry_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_hit             (rsp_hit),
      .rsp_result_flags    (rsp_result_flags),
      .rsp_entry_host      (rsp_entry_host),
      .rsp_entry_mask      (rsp_entry_mask),
      .rsp_entry_temporary (rsp_entry_temporary),
      .rsp_entry_count     (rsp_entry_count)
   );

   function automatic void store_entry(input int pos, input logic [31:0] host,
                                       input logic [31:0] mask, input logic [3:0] flags,
                                       input logic temporary);
      acl_host[pos]  = host;
      acl_mask[pos]  = mask;
      acl_flags[pos] = flags;
      acl_temp[pos]  = temporary;
   endfunction

   // Apply one request to the shadow table and return the response it must give.
   function automatic filter_response_type apply_filter_request(
         input logic [2:0] fn, input logic [31:0] addr, input logic [31:0] mask,
         input logic [3:0] flags, input logic [5:0] idx);
      filter_response_type rsp;
      int i;
      int kept;
      bit found;
      rsp = '0;
      rsp.status = ST_NOT_FOUND;
      found = 1'b0;
      case (fn)
         FN_LOOKUP: begin
            // first match from the front wins
            for (i = 0; i < acl_count && !found; i++) begin
               if ((addr & acl_mask[i]) == acl_host[i]) begin
                  found = 1'b1;
                  rsp.status = ST_OK;
                  rsp.hit = 1'b1;
                  rsp.flags = acl_flags[i];
               end
            end
         end
         FN_APPEND: begin
            if (acl_count >= TABLE_ENTRIES) begin
               rsp.status = ST_FULL;
            end else begin
               store_entry(acl_count, addr & mask, mask, flags, 1'b0);
               acl_count++;
               rsp.status = ST_OK;
            end
         end
         FN_BAN: begin
            // overwrite every exact host match; the host is kept unmasked
            for (i = 0; i < acl_count; i++) begin
               if (acl_host[i] == addr) begin
                  store_entry(i, addr, mask, FLAG_BANNED, 1'b1);
                  found = 1'b1;
               end
            end
            if (found) begin
               rsp.status = ST_REPLACED;
            end else if (acl_count >= TABLE_ENTRIES) begin
               rsp.status = ST_FULL;
            end else begin
               for (i = acl_count; i > 0; i--) begin
                  store_entry(i, acl_host[i-1], acl_mask[i-1], acl_flags[i-1], acl_temp[i-1]);
               end
               store_entry(0, addr, mask, FLAG_BANNED, 1'b1);
               acl_count++;
               rsp.status = ST_OK;
            end
         end
         FN_REMOVE: begin
            // compact the survivors towards the front, keeping their order
            kept = 0;
            for (i = 0; i < acl_count; i++) begin
               if (acl_host[i] != addr) begin
                  if (kept != i) begin
                     store_entry(kept, acl_host[i], acl_mask[i], acl_flags[i], acl_temp[i]);
                  end
                  kept++;
               end
            end
            rsp.status = (kept != acl_count) ? ST_REMOVED : ST_NOT_FOUND;
            acl_count = kept;
         end
         FN_READ: begin
            if (idx < acl_count) begin
               rsp.status = ST_OK;
               rsp.flags = acl_flags[idx];
               rsp.host = acl_host[idx];
               rsp.mask = acl_mask[idx];
               rsp.temporary = acl_temp[idx];
            end
         end
         FN_CLEAR: begin
            acl_count = 0;
            rsp.status = ST_OK;
         end
         default: begin
         end
      endcase
      rsp.count = 7'(acl_count);
      return rsp;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Check responses against the oldest prediction, predict accepted requests,
   // and stop the run if the block makes no progress while work is outstanding.
   always @(posedge clock) begin : track_handshakes
      filter_response_type want;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            rsp_taken <= rsp_taken + 1;
            if (awaited_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual status %0h",
                        $time, rsp_status);
               error_count++;
            end else begin
               want = awaited_responses.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("hit", 32'(want.hit), 32'(rsp_hit));
               compare_field("result_flags", 32'(want.flags), 32'(rsp_result_flags));
               compare_field("entry_host", want.host, rsp_entry_host);
               compare_field("entry_mask", want.mask, rsp_entry_mask);
               compare_field("entry_temporary", 32'(want.temporary),
                             32'(rsp_entry_temporary));
               compare_field("entry_count", 32'(want.count), 32'(rsp_entry_count));
            end
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            req_taken <= req_taken + 1;
            awaited_responses.push_back(apply_filter_request(req_func, req_host_addr,
               req_net_mask, req_policy_flags, req_entry_index));
         end
         if (moved || (awaited_responses.size() == 0 && !req_valid)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Response side: random stall per response, or one long hold-off on request.
   initial begin : response_sink
      int unsigned stall;
      int unsigned seen;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = sink_quiet ? 0 : $urandom_range(MAX_GAP, 0);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         seen = rsp_taken;
         do @(negedge clock); while (rsp_taken == seen);
      end
   end

   // Offer one request and hold it until accepted. Called and returns at a falling edge.
   task automatic send_filter_request(input logic [2:0] fn, input logic [31:0] addr,
                                      input logic [31:0] mask, input logic [3:0] flags,
                                      input logic [5:0] idx);
      int unsigned gap;
      int unsigned seen;
      gap = source_quiet ? 0 : $urandom_range(MAX_GAP, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= fn;
      req_host_addr    <= addr;
      req_net_mask     <= mask;
      req_policy_flags <= flags;
      req_entry_index  <= idx;
      seen = req_taken;
      do @(negedge clock); while (req_taken == seen);
   endtask

   function automatic logic [31:0] pick_mask();
      int unsigned r;
      int unsigned len;
      r = $urandom_range(99, 0);
      len = $urandom_range(32, 0);
      if (r < 40) return 32'hffff_ffff << (32 - len);
      if (r < 65) return 32'hffff_ffff;
      if (r < 75) return 32'h0;
      return $urandom;
   endfunction

   // Favour hosts already held so that bans replace and removes find something.
   function automatic logic [31:0] pick_host();
      int unsigned r;
      r = $urandom_range(99, 0);
      if (r < 35 && acl_count > 0) return acl_host[$urandom_range(acl_count - 1, 0)];
      if (r < 80) return host_pool[$urandom_range(POOL_SIZE - 1, 0)];
      return $urandom;
   endfunction

   // One random request shaped by the current table; clear_pm is the clear rate per mille.
   task automatic send_random_request(input int unsigned clear_pm);
      logic [2:0]  fn;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [3:0]  flags;
      logic [5:0]  idx;
      int unsigned r;
      int unsigned j;
      // fill every field, used or not, so that all bits toggle
      addr  = $urandom;
      mask  = $urandom;
      flags = 4'($urandom_range(15, 0));
      idx   = 6'($urandom_range(63, 0));
      r = $urandom_range(999, 0);
      if (r < clear_pm) begin
         fn = FN_CLEAR;
      end else if (r < clear_pm + 10) begin
         fn = $urandom_range(1, 0) ? FN_SPARE6 : FN_SPARE7;
      end else begin
         r = $urandom_range(99, 0);
         if (r < 30) begin
            fn = FN_LOOKUP;
            if (acl_count > 0 && $urandom_range(99, 0) < 60) begin
               // aim at one entry, random outside its mask
               j = $urandom_range(acl_count - 1, 0);
               addr = (acl_host[j] & acl_mask[j]) | ($urandom & ~acl_mask[j]);
            end else begin
               addr = pick_host();
            end
         end else if (r < 58) begin
            fn = FN_APPEND;
            addr = pick_host();
            mask = pick_mask();
         end else if (r < 70) begin
            fn = FN_BAN;
            addr = pick_host();
            mask = pick_mask();
         end else if (r < 80) begin
            fn = FN_REMOVE;
            addr = pick_host();
         end else begin
            fn = FN_READ;
            if (acl_count > 0 && $urandom_range(99, 0) < 75) begin
               idx = 6'($urandom_range(acl_count - 1, 0));
            end
         end
      end
      send_filter_request(fn, addr, mask, flags, idx);
   endtask

   task automatic test_empty_table();
      send_filter_request(FN_LOOKUP, 32'hffff_ffff, '0, '0, '0);
      send_filter_request(FN_READ, '0, '0, '0, 6'd0);
      send_filter_request(FN_REMOVE, 32'h0, '0, '0, '0);
      send_filter_request(FN_SPARE6, 32'h1234_5678, 32'hffff_ffff, 4'hf, 6'd63);
      send_filter_request(FN_SPARE7, 32'h0, 32'h0, 4'h0, 6'd0);
   endtask

   task automatic test_table_operations();
      // one exact host, a /8, a /24 and a catch-all entry, in that order
      send_filter_request(FN_APPEND, 32'hffff_ffff, 32'hffff_ffff, 4'hf, '0);
      send_filter_request(FN_APPEND, 32'h0a12_3456, 32'hff00_0000, 4'h2, '0);
      send_filter_request(FN_APPEND, 32'hc0a8_0105, 32'hffff_ff00, 4'h4, '0);
      send_filter_request(FN_APPEND, 32'h5555_aaaa, 32'h0000_0000, 4'h8, '0);
      send_filter_request(FN_LOOKUP, 32'hffff_ffff, '0, '0, '0);
      send_filter_request(FN_LOOKUP, 32'h0a7f_0001, '0, '0, '0);
      send_filter_request(FN_LOOKUP, 32'hc0a8_01fe, '0, '0, '0);
      send_filter_request(FN_LOOKUP, 32'h0102_0304, '0, '0, '0);
      // ban of a held host replaces it in place; a new one goes to the front
      send_filter_request(FN_BAN, 32'h0a00_0000, 32'hffff_0000, 4'h6, '0);
      send_filter_request(FN_BAN, 32'hc0a8_0001, 32'hffff_ffff, 4'h0, '0);
      send_filter_request(FN_READ, '0, '0, '0, 6'd0);
      send_filter_request(FN_READ, '0, '0, '0, 6'd2);
      send_filter_request(FN_READ, '0, '0, '0, 6'd4);
      send_filter_request(FN_READ, '0, '0, '0, 6'd5);
      // duplicate hosts: one ban rewrites both, one remove drops both
      send_filter_request(FN_APPEND, 32'h0b00_00ff, 32'hff00_0000, 4'h0, '0);
      send_filter_request(FN_APPEND, 32'h0b00_0000, 32'hffff_0000, 4'h1, '0);
      send_filter_request(FN_BAN, 32'h0b00_0000, 32'hff00_ff00, 4'h0, '0);
      send_filter_request(FN_REMOVE, 32'h0b00_0000, '0, '0, '0);
      send_filter_request(FN_REMOVE, 32'h0b00_0000, '0, '0, '0);
      send_filter_request(FN_LOOKUP, 32'h0b00_0001, '0, '0, '0);
      send_filter_request(FN_READ, '0, '0, '0, 6'd63);
      send_filter_request(FN_CLEAR, '0, '0, '0, '0);
   endtask

   task automatic test_full_table();
      int i;
      send_filter_request(FN_CLEAR, $urandom, $urandom, '0, '0);
      while (acl_count < TABLE_ENTRIES) begin
         send_filter_request(FN_APPEND, pick_host(), pick_mask(),
                             4'($urandom_range(15, 0)), '0);
      end
      // append and front insert must both be refused; a replacing ban still lands
      send_filter_request(FN_APPEND, $urandom, pick_mask(), 4'hf, '0);
      send_filter_request(FN_BAN, $urandom, pick_mask(), '0, '0);
      send_filter_request(FN_BAN, acl_host[TABLE_ENTRIES - 1], 32'hffff_ffff, '0, '0);
      send_filter_request(FN_READ, '0, '0, '0, 6'(TABLE_ENTRIES - 1));
      send_filter_request(FN_REMOVE, acl_host[0], '0, '0, '0);
      send_filter_request(FN_BAN, $urandom, 32'hffff_ff00, '0, '0);
      // churn near the top with no clears
      for (i = 0; i < 150; i++) begin
         send_random_request(0);
      end
   endtask

   task automatic test_receiver_hold_off();
      int i;
      // stall the response side long enough for the block to refuse requests
      hold_off_cycles = HOLD_OFF_LEN;
      for (i = 0; i < 20; i++) begin
         send_random_request(20);
      end
   endtask

   task automatic test_random_mix();
      int phase;
      int i;
      int unsigned clear_pm;
      for (phase = 0; phase < 13; phase++) begin
         // quiet phases give back-to-back traffic on one or both sides
         source_quiet = ($urandom_range(3, 0) == 0);
         sink_quiet   = ($urandom_range(3, 0) == 0);
         case ($urandom_range(2, 0))
            0: clear_pm = 5;
            1: clear_pm = 20;
            default: clear_pm = 60;
         endcase
         for (i = 0; i < 100; i++) begin
            send_random_request(clear_pm);
         end
      end
      source_quiet = 1'b0;
      sink_quiet   = 1'b0;
   endtask

   initial begin : run_tests
      int i;
      for (i = 0; i < POOL_SIZE; i++) begin
         host_pool[i] = $urandom;
      end
      host_pool[0] = 32'h0;
      host_pool[1] = 32'hffff_ffff;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_table_operations();
      test_full_table();
      test_receiver_hold_off();
      test_random_mix();

      // drop valid, drain the outstanding responses, then let the block settle
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
